### src/sks_pkg.sv
// ----------------------------------------------------------------------------
// sks_pkg: shared definitions of the sorted key set
// action codes, default sizes and the compare result struct
// ----------------------------------------------------------------------------
`default_nettype none

package sks_pkg;

	// default sizes
	localparam int TABLE_DEPTH_DEF = 256;
	localparam int KEY_BYTES_DEF   = 8;

	// fixed field widths of the ports
	localparam int KEY_PORT_W = 64;
	localparam int ACTION_W   = 2;
	localparam int OUT_W      = 9;

	// action codes
	localparam logic [ACTION_W-1:0] ACT_INSERT = 2'd0;
	localparam logic [ACTION_W-1:0] ACT_REMOVE = 2'd1;
	localparam logic [ACTION_W-1:0] ACT_QUERY  = 2'd2;

	// result of comparing the probe key with one table entry
	typedef struct packed {
		logic eq;  // probe equals entry
		logic lt;  // probe below entry
	} cmp_t;

endpackage

`default_nettype wire

### src/sks_ram.sv
// ----------------------------------------------------------------------------
// sks_ram: generic single-port-write, single-port-read ram
// one write and one registered read per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module sks_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data <= mem_q[rd_addr];
	end

endmodule

`default_nettype wire

### src/sks_cmp.sv
// ----------------------------------------------------------------------------
// sks_cmp: key comparator
// unsigned compare of the probe key against one stored entry
// ----------------------------------------------------------------------------
`default_nettype none

module sks_cmp #(
	parameter int KEY_W = 64
) (
	input  wire logic [KEY_W-1:0] probe,
	input  wire logic [KEY_W-1:0] entry,
	output sks_pkg::cmp_t         result
);

	// unsigned order of zero-padded words matches lexicographic order
	assign result.eq = (probe == entry);
	assign result.lt = (probe < entry);

endmodule

`default_nettype wire

### src/sorted_key_set.sv
// ----------------------------------------------------------------------------
// sorted_key_set: ordered set of distinct keys
// binary search over a ram-held sorted table with insert and remove by shifting
// ----------------------------------------------------------------------------
// Each transaction carries an action (insert if absent, remove if present,
// query; the unused code acts as a query) and a key of up to KEY_BYTES bytes,
// of which only the low 8*KEY_BYTES bits count. One result transaction comes
// back per request: found, rejected_full, position (index or insertion point)
// and entry_count after the request, the last two truncated to 9 bits. The
// block works on one request at a time and holds in_stall high until it has
// handed its result to the output register. A request makes up to
// ceil(log2(n+1)) binary search probes for n held keys, each a ram read issued
// in S_PROBE and compared in S_COMPARE, then S_DECIDE; an insert or a remove
// moves each shifted entry with a read in S_MOVE_RD and a write in S_MOVE_WR, and
// S_DONE waits while the previous result is held by out_stall; the single ram
// read port with its registered read sets this order. Contents are undefined
// after reset and need no clearing: only entries below the held count are used.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_key_set #(
	parameter int TABLE_DEPTH = sks_pkg::TABLE_DEPTH_DEF,
	parameter int KEY_BYTES   = sks_pkg::KEY_BYTES_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	// request channel
	input  wire logic                            in_valid,
	output logic                                 in_stall,
	input  wire logic [sks_pkg::ACTION_W-1:0]    action,
	input  wire logic [sks_pkg::KEY_PORT_W-1:0]  key,
	// result channel
	output logic                                 out_valid,
	input  wire logic                            out_stall,
	output logic                                 found,
	output logic                                 rejected_full,
	output logic      [sks_pkg::OUT_W-1:0]       position,
	output logic      [sks_pkg::OUT_W-1:0]       entry_count
);

	localparam int KEY_W  = 8 * KEY_BYTES;
	localparam int ADDR_W = $clog2(TABLE_DEPTH);
	localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
	localparam int EXT_W  = CNT_W + sks_pkg::OUT_W;
	localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(TABLE_DEPTH);

	typedef enum logic [2:0] {
		S_IDLE,
		S_PROBE,
		S_COMPARE,
		S_DECIDE,
		S_MOVE_RD,
		S_MOVE_WR,
		S_DONE
	} state_t;

	state_t                     state_q;
	logic [sks_pkg::ACTION_W-1:0] action_q;
	logic [KEY_W-1:0]           key_q;
	logic [CNT_W-1:0]           count_q;   // keys held
	logic [CNT_W-1:0]           lo_q;      // search window [lo, hi)
	logic [CNT_W-1:0]           hi_q;
	logic [CNT_W-1:0]           mid_q;     // entry under compare
	logic [CNT_W-1:0]           pos_q;     // index or insertion point
	logic [CNT_W-1:0]           sp_q;      // shift pointer, entry being written
	logic                       hit_q;
	logic                       refused_q;
	logic                       rm_q;      // shift toward lower indexes (remove)
	logic                       out_valid_q;
	logic                       found_q;
	logic                       rejected_q;
	logic [sks_pkg::OUT_W-1:0]  position_q;
	logic [sks_pkg::OUT_W-1:0]  count_out_q;

	// ram controls
	logic                       ram_wr_en;
	logic [ADDR_W-1:0]          ram_wr_addr;
	logic [KEY_W-1:0]           ram_wr_data;
	logic [ADDR_W-1:0]          ram_rd_addr;
	logic [KEY_W-1:0]           ram_rd_data;

	sks_pkg::cmp_t              cmp;

	// search and shift helpers
	logic [CNT_W-1:0]           mid;
	logic [CNT_W-1:0]           sp_next;
	logic [CNT_W-1:0]           sp_prev;
	logic                       more_moves;
	logic                       out_free;
	logic [EXT_W-1:0]           pos_ext;
	logic [EXT_W-1:0]           cnt_ext;

	sks_ram #(
		.WIDTH(KEY_W),
		.DEPTH(TABLE_DEPTH)
	) u_table (
		.clk    (clk),
		.wr_en  (ram_wr_en),
		.wr_addr(ram_wr_addr),
		.wr_data(ram_wr_data),
		.rd_addr(ram_rd_addr),
		.rd_data(ram_rd_data)
	);

	// one shared comparator serves every probe of the search
	sks_cmp #(
		.KEY_W(KEY_W)
	) u_cmp (
		.probe (key_q),
		.entry (ram_rd_data),
		.result(cmp)
	);

	assign mid     = lo_q + ((hi_q - lo_q) >> 1);
	assign sp_next = sp_q + CNT_W'(1);
	assign sp_prev = sp_q - CNT_W'(1);
	// insert opens a gap at pos from the top down, remove closes it bottom up
	assign more_moves = rm_q ? (sp_next < count_q) : (sp_q > pos_q);
	assign out_free   = !out_valid_q || !out_stall;

	// widen before truncating so any depth maps onto the 9-bit fields
	assign pos_ext = EXT_W'(pos_q);
	assign cnt_ext = EXT_W'(count_q);

	assign in_stall = (state_q != S_IDLE);

	// ram address and write selection
	always_comb begin
		ram_wr_en   = 1'b0;
		ram_wr_addr = sp_q[ADDR_W-1:0];
		ram_wr_data = ram_rd_data;
		ram_rd_addr = mid[ADDR_W-1:0];
		unique case (state_q)
			S_MOVE_RD: begin
				ram_rd_addr = rm_q ? sp_next[ADDR_W-1:0] : sp_prev[ADDR_W-1:0];
				// gap reached: drop the new key into place
				if (!more_moves && !rm_q) begin
					ram_wr_en   = 1'b1;
					ram_wr_addr = pos_q[ADDR_W-1:0];
					ram_wr_data = key_q;
				end
			end
			S_MOVE_WR: begin
				ram_wr_en = 1'b1;
			end
			default: begin
			end
		endcase
	end

	// sequencer, state and registered outputs
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// new result loaded, or the held one taken downstream
			if (state_q == S_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						action_q  <= action;
						key_q     <= key[KEY_W-1:0];
						lo_q      <= '0;
						hi_q      <= count_q;
						hit_q     <= 1'b0;
						refused_q <= 1'b0;
						state_q   <= S_PROBE;
					end
				end
				S_PROBE: begin
					if (lo_q < hi_q) begin
						// read of mid issued this cycle
						mid_q   <= mid;
						state_q <= S_COMPARE;
					end else begin
						pos_q   <= lo_q;
						state_q <= S_DECIDE;
					end
				end
				S_COMPARE: begin
					priority if (cmp.eq) begin
						hit_q   <= 1'b1;
						pos_q   <= mid_q;
						state_q <= S_DECIDE;
					end else if (cmp.lt) begin
						hi_q    <= mid_q;
						state_q <= S_PROBE;
					end else begin
						lo_q    <= mid_q + CNT_W'(1);
						state_q <= S_PROBE;
					end
				end
				S_DECIDE: begin
					priority if (action_q == sks_pkg::ACT_INSERT && !hit_q) begin
						if (count_q == DEPTH_C) begin
							refused_q <= 1'b1;
							state_q   <= S_DONE;
						end else begin
							sp_q    <= count_q;
							rm_q    <= 1'b0;
							state_q <= S_MOVE_RD;
						end
					end else if (action_q == sks_pkg::ACT_REMOVE && hit_q) begin
						sp_q    <= pos_q;
						rm_q    <= 1'b1;
						state_q <= S_MOVE_RD;
					end else begin
						// query, unused code, or nothing to change
						state_q <= S_DONE;
					end
				end
				S_MOVE_RD: begin
					if (more_moves) begin
						state_q <= S_MOVE_WR;
					end else begin
						count_q <= rm_q ? (count_q - CNT_W'(1)) : (count_q + CNT_W'(1));
						state_q <= S_DONE;
					end
				end
				S_MOVE_WR: begin
					sp_q    <= rm_q ? sp_next : sp_prev;
					state_q <= S_MOVE_RD;
				end
				S_DONE: begin
					if (out_free) begin
						found_q     <= hit_q;
						rejected_q  <= refused_q;
						position_q  <= pos_ext[sks_pkg::OUT_W-1:0];
						count_out_q <= cnt_ext[sks_pkg::OUT_W-1:0];
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid     = out_valid_q;
	assign found         = found_q;
	assign rejected_full = rejected_q;
	assign position      = position_q;
	assign entry_count   = count_out_q;

endmodule

`default_nettype wire

### tb/sorted_key_set_tb.sv
// ----------------------------------------------------------------------------
// sorted_key_set_tb: self-checking regression of the sorted key set
// random bursts of insert, remove and query requests against a queue-based
// model of the ordered set; results checked in order against expectations
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_key_set_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int TABLE_DEPTH  = sks_pkg::TABLE_DEPTH_DEF;
	localparam int KEY_BYTES    = sks_pkg::KEY_BYTES_DEF;
	localparam int POOL_SIZE    = 320;
	localparam int HOT_SIZE     = 16;
	// longest request: full search plus a shift across the whole table
	localparam int DRAIN_CYCLES = 1200;
	localparam int TIMEOUT_NS   = 30_000_000;
	localparam int REPORT_LIMIT = 10;

	// the package names three action codes, the fourth one acts as a query
	localparam logic [sks_pkg::ACTION_W-1:0] ACT_UNUSED = 2'd3;

	localparam logic [sks_pkg::KEY_PORT_W-1:0] KEY_MASK =
		{sks_pkg::KEY_PORT_W{1'b1}} >> (sks_pkg::KEY_PORT_W - 8 * KEY_BYTES);
	localparam logic [sks_pkg::KEY_PORT_W-1:0] KEY_TOP = {sks_pkg::KEY_PORT_W{1'b1}};

	typedef struct packed {
		logic [sks_pkg::ACTION_W-1:0]   act;
		logic [sks_pkg::KEY_PORT_W-1:0] k;
	} set_request_t;

	typedef struct packed {
		logic                      found;
		logic                      rejected_full;
		logic [sks_pkg::OUT_W-1:0] position;
		logic [sks_pkg::OUT_W-1:0] entry_count;
	} set_reply_t;

	// receiver stall patterns
	typedef enum logic [1:0] {
		STALL_NONE,
		STALL_LIGHT,
		STALL_HEAVY,
		STALL_PERIODIC
	} stall_mode_t;

	// dut ports, the driven ones known from time zero
	logic                           clk           = 1'b0;
	logic                           arst_n        = 1'b0;
	logic                           in_valid      = 1'b0;
	logic                           in_stall;
	logic [sks_pkg::ACTION_W-1:0]   action        = sks_pkg::ACT_QUERY;
	logic [sks_pkg::KEY_PORT_W-1:0] key           = '0;
	logic                           out_valid;
	logic                           out_stall     = 1'b0;
	logic                           found;
	logic                           rejected_full;
	logic [sks_pkg::OUT_W-1:0]      position;
	logic [sks_pkg::OUT_W-1:0]      entry_count;

	// stimulus still to send, and results still owed by the dut
	set_request_t          request_q[$];
	set_reply_t            reply_q[$];

	// model state: the held keys, kept in ascending order
	logic [sks_pkg::KEY_PORT_W-1:0] held_keys[$];

	// key pools used to build the stimulus
	logic [sks_pkg::KEY_PORT_W-1:0] pool[POOL_SIZE];
	logic [sks_pkg::KEY_PORT_W-1:0] hot_keys[HOT_SIZE];
	bit                             seen_key[logic [sks_pkg::KEY_PORT_W-1:0]];

	int                    fail_count = 0;

	sorted_key_set u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.action        (action),
		.key           (key),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.found         (found),
		.rejected_full (rejected_full),
		.position      (position),
		.entry_count   (entry_count)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// ------------------------------------------------------------------------
	// model of the set: lower-bound search, then insert, remove or nothing
	// ------------------------------------------------------------------------
	function automatic set_reply_t apply_request(
			input logic [sks_pkg::ACTION_W-1:0] act,
			input logic [sks_pkg::KEY_PORT_W-1:0] raw_key);
		int                             lo;
		int                             hi;
		int                             mid;
		logic                           hit;
		logic [sks_pkg::KEY_PORT_W-1:0] k;
		set_reply_t                     r;
		k  = raw_key & KEY_MASK;
		lo = 0;
		hi = held_keys.size();
		while (lo < hi) begin
			mid = (lo + hi) / 2;
			if (held_keys[mid] < k) begin
				lo = mid + 1;
			end else begin
				hi = mid;
			end
		end
		hit = (lo < held_keys.size()) && (held_keys[lo] == k);
		r = '0;
		r.found    = hit;
		r.position = lo[sks_pkg::OUT_W-1:0];
		if (act == sks_pkg::ACT_INSERT && !hit) begin
			// a full table refuses the key and keeps its contents
			if (held_keys.size() >= TABLE_DEPTH) begin
				r.rejected_full = 1'b1;
			end else begin
				held_keys.insert(lo, k);
			end
		end else if (act == sks_pkg::ACT_REMOVE && hit) begin
			held_keys.delete(lo);
		end
		// query and the unused code change nothing
		r.entry_count = sks_pkg::OUT_W'(held_keys.size());
		return r;
	endfunction

	// packs a word first character highest, zero padded
	function automatic logic [sks_pkg::KEY_PORT_W-1:0] word_key(input string s);
		logic [sks_pkg::KEY_PORT_W-1:0] w;
		w = '0;
		for (int i = 0; i < 8 && i < s.len(); i++) begin
			w[sks_pkg::KEY_PORT_W-1-8*i -: 8] = s[i];
		end
		return w;
	endfunction

	task automatic shuffle_pool();
		int                             j;
		logic [sks_pkg::KEY_PORT_W-1:0] t;
		for (int i = POOL_SIZE - 1; i > 0; i--) begin
			j       = $urandom_range(0, i);
			t       = pool[i];
			pool[i] = pool[j];
			pool[j] = t;
		end
	endtask

	task automatic add_request(input logic [sks_pkg::ACTION_W-1:0] act,
			input logic [sks_pkg::KEY_PORT_W-1:0] k);
		request_q.push_back('{act: act, k: k});
	endtask

	task automatic note_failure(input string what, input set_reply_t want,
			input set_reply_t got);
		if (fail_count < REPORT_LIMIT) begin
			$display({"%0t mismatch (%s): expected found=%b rej=%b pos=%0d cnt=%0d,",
				" got found=%b rej=%b pos=%0d cnt=%0d"},
				$realtime, what, want.found, want.rejected_full, want.position,
				want.entry_count, got.found, got.rejected_full, got.position,
				got.entry_count);
		end
		fail_count++;
	endtask

	// ------------------------------------------------------------------------
	// request driver: bursts of random length separated by random gaps
	// ------------------------------------------------------------------------
	int           burst_left = 0;
	int           gap_left   = 0;
	logic         offering;
	set_request_t next_req;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid   <= 1'b0;
			action     <= sks_pkg::ACT_QUERY;
			key        <= '0;
			burst_left = 0;
			gap_left   = 0;
		end else begin
			offering = in_valid;
			// transaction accepted: the model sees it in the same order as the dut
			if (in_valid && !in_stall) begin
				reply_q.push_back(apply_request(action, key));
				offering = 1'b0;
				if (burst_left > 0) begin
					burst_left--;
				end
			end
			if (!offering) begin
				if (burst_left == 0) begin
					burst_left = $urandom_range(1, 16);
					// a quarter of the bursts follow straight on
					gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
				end
				if (gap_left > 0) begin
					gap_left--;
				end else if (request_q.size() != 0) begin
					next_req = request_q.pop_front();
					offering = 1'b1;
					action   <= next_req.act;
					key      <= next_req.k;
				end
			end
			// payload holds while stalled since offering stays high
			in_valid <= offering;
		end
	end

	// ------------------------------------------------------------------------
	// receiver stall: a random pattern, picked anew whenever its run ends
	// ------------------------------------------------------------------------
	stall_mode_t stall_mode = STALL_NONE;
	int          mode_left  = 0;
	int          stall_tick = 0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall  <= 1'b0;
			stall_mode = STALL_NONE;
			mode_left  = 0;
			stall_tick = 0;
		end else begin
			if (mode_left == 0) begin
				stall_mode = stall_mode_t'($urandom_range(0, 3));
				mode_left  = $urandom_range(20, 300);
			end else begin
				mode_left--;
			end
			stall_tick++;
			case (stall_mode)
				STALL_NONE: begin
					out_stall <= 1'b0;
				end
				STALL_LIGHT: begin
					out_stall <= ($urandom_range(0, 3) == 0);
				end
				STALL_HEAVY: begin
					out_stall <= ($urandom_range(0, 9) < 7);
				end
				default: begin
					out_stall <= ((stall_tick % 5) < 2);
				end
			endcase
		end
	end

	// ------------------------------------------------------------------------
	// result monitor: each accepted result against the oldest expectation
	// ------------------------------------------------------------------------
	set_reply_t seen_reply;
	set_reply_t want_reply;

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			seen_reply = '{found: found, rejected_full: rejected_full,
				position: position, entry_count: entry_count};
			if (reply_q.size() == 0) begin
				note_failure("result with none pending", 'x, seen_reply);
			end else begin
				want_reply = reply_q.pop_front();
				if (seen_reply.found !== want_reply.found
						|| seen_reply.rejected_full !== want_reply.rejected_full
						|| seen_reply.position !== want_reply.position
						|| seen_reply.entry_count !== want_reply.entry_count) begin
					note_failure("field", want_reply, seen_reply);
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// stimulus, reset and end of run
	// ------------------------------------------------------------------------
	initial begin
		logic [sks_pkg::KEY_PORT_W-1:0] w;
		int                             len;
		int                             r;

		// directed: empty table, extremes, duplicates, prefixes, spare code
		add_request(sks_pkg::ACT_QUERY,  '0);
		add_request(sks_pkg::ACT_REMOVE, KEY_TOP);
		add_request(sks_pkg::ACT_INSERT, KEY_TOP);
		add_request(sks_pkg::ACT_INSERT, '0);
		add_request(sks_pkg::ACT_INSERT, '0);
		add_request(sks_pkg::ACT_INSERT, word_key("apple"));
		add_request(sks_pkg::ACT_INSERT, word_key("apples"));
		add_request(sks_pkg::ACT_QUERY,  word_key("apple"));
		add_request(ACT_UNUSED, word_key("zebra"));
		add_request(ACT_UNUSED, '0);
		add_request(sks_pkg::ACT_REMOVE, word_key("banana"));
		add_request(sks_pkg::ACT_REMOVE, word_key("apple"));
		add_request(sks_pkg::ACT_QUERY,  KEY_TOP);
		add_request(sks_pkg::ACT_INSERT, 64'h8000_0000_0000_0000);
		add_request(sks_pkg::ACT_INSERT, 64'h7fff_ffff_ffff_ffff);
		add_request(sks_pkg::ACT_REMOVE, '0);
		add_request(sks_pkg::ACT_REMOVE, KEY_TOP);
		add_request(sks_pkg::ACT_QUERY,  64'h8000_0000_0000_0000);
		add_request(sks_pkg::ACT_INSERT, {$urandom, $urandom});

		// distinct pool: random words and raw random keys
		seen_key[word_key("apples")]    = 1'b1;
		seen_key[64'h8000_0000_0000_0000] = 1'b1;
		seen_key[64'h7fff_ffff_ffff_ffff] = 1'b1;
		for (int i = 0; i < POOL_SIZE; i++) begin
			do begin
				if ($urandom_range(0, 3) == 0) begin
					w   = '0;
					len = $urandom_range(1, 8);
					for (int j = 0; j < len; j++) begin
						w[sks_pkg::KEY_PORT_W-1-8*j -: 8] = 8'h61 + 8'($urandom_range(0, 25));
					end
				end else begin
					w = {$urandom, $urandom};
				end
			end while (seen_key.exists(w));
			seen_key[w] = 1'b1;
			pool[i]     = w;
		end

		// fill well past the depth so the table runs full and refuses keys
		shuffle_pool();
		for (int i = 0; i < 276; i++) begin
			add_request(sks_pkg::ACT_INSERT, pool[i]);
			if ($urandom_range(0, 7) == 0) begin
				add_request(sks_pkg::ACT_QUERY, pool[$urandom_range(0, POOL_SIZE - 1)]);
			end
		end

		// work at the full boundary: refused inserts, and remove then refill
		for (int i = 0; i < 80; i++) begin
			r = $urandom_range(0, 9);
			if (r < 4) begin
				add_request(sks_pkg::ACT_INSERT, pool[$urandom_range(0, POOL_SIZE - 1)]);
			end else if (r == 4) begin
				add_request(sks_pkg::ACT_INSERT, {$urandom, $urandom});
			end else if (r < 7) begin
				add_request(sks_pkg::ACT_QUERY, pool[$urandom_range(0, POOL_SIZE - 1)]);
			end else if (r == 7) begin
				add_request(ACT_UNUSED, pool[$urandom_range(0, POOL_SIZE - 1)]);
			end else begin
				add_request(sks_pkg::ACT_REMOVE, pool[$urandom_range(0, POOL_SIZE - 1)]);
				add_request(sks_pkg::ACT_INSERT, {$urandom, $urandom});
			end
		end

		// drain: every pool key removed once, in a fresh order
		shuffle_pool();
		for (int i = 0; i < POOL_SIZE; i++) begin
			add_request(sks_pkg::ACT_REMOVE, pool[i]);
			if ($urandom_range(0, 5) == 0) begin
				add_request(sks_pkg::ACT_QUERY, pool[$urandom_range(0, POOL_SIZE - 1)]);
			end
		end

		// mixed traffic on a small hot set so hits and misses both come often
		hot_keys[0] = '0;
		hot_keys[1] = KEY_TOP;
		for (int i = 2; i < HOT_SIZE; i++) begin
			hot_keys[i] = pool[i];
		end
		for (int i = 0; i < 560; i++) begin
			w = ($urandom_range(0, 19) < 17) ? hot_keys[$urandom_range(0, HOT_SIZE - 1)]
				: {$urandom, $urandom};
			r = $urandom_range(0, 99);
			if (r < 35) begin
				add_request(sks_pkg::ACT_INSERT, w);
			end else if (r < 65) begin
				add_request(sks_pkg::ACT_REMOVE, w);
			end else if (r < 90) begin
				add_request(sks_pkg::ACT_QUERY, w);
			end else begin
				add_request(ACT_UNUSED, w);
			end
		end

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// all requests sent and every owed result back
		while (request_q.size() != 0 || in_valid || reply_q.size() != 0) begin
			@(posedge clk);
		end
		// room for a stray extra result to show up
		repeat (DRAIN_CYCLES) @(posedge clk);
		while (reply_q.size() != 0) begin
			note_failure("result never came", reply_q.pop_front(), 'x);
		end

		if (fail_count == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

	// hang guard
	initial begin
		#(TIMEOUT_NS);
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule

`default_nettype wire
